// ----- src/lmtc_pkg.sv -----
// ----------------------------------------------------------------------------
// LCD mode timing controller package
// Shared types and timing constants for the scanline dot sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package lmtc_pkg;

    localparam int unsigned DOT_W  = 10;
    localparam int unsigned LINE_W = 8;

    localparam logic [DOT_W-1:0]  LINE_DOTS    = 10'd456;
    localparam logic [DOT_W-1:0]  OAM_END      = 10'd79;
    localparam logic [DOT_W-1:0]  XFER_END     = 10'd251;
    localparam logic [DOT_W-1:0]  HBLANK_END   = 10'd455;
    localparam logic [LINE_W-1:0] ACTIVE_LINES = 8'd144;
    localparam logic [LINE_W-1:0] FRAME_LINES  = 8'd154;

    typedef enum logic [1:0] {
        LCD_HBLANK = 2'd0,
        LCD_VBLANK = 2'd1,
        LCD_OAM    = 2'd2,
        LCD_XFER   = 2'd3
    } lcd_mode_t;

    typedef enum logic [2:0] {
        REG_DISPLAY_ENABLE     = 3'd0,
        REG_COMPARE_LINE       = 3'd1,
        REG_HBLANK_IRQ_ENABLE  = 3'd2,
        REG_OAM_IRQ_ENABLE     = 3'd3,
        REG_COMPARE_IRQ_ENABLE = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic              display_enable;
        logic [LINE_W-1:0] compare_line;
        logic              hblank_irq_enable;
        logic              oam_irq_enable;
        logic              compare_irq_enable;
    } cfg_t;

    typedef struct packed {
        logic [LINE_W-1:0] line_number;
        lcd_mode_t         lcd_mode;
        logic              coincidence;
        logic              vblank_irq;
        logic              mode_irq;
        logic              compare_irq;
        logic              render_request;
        logic              frame_done;
    } result_t;

endpackage

`default_nettype wire

// ----- src/lmtc_cfg.sv -----
// ----------------------------------------------------------------------------
// LCD mode timing controller configuration registers
// Holds the enable, compare line and interrupt enable registers.
// ----------------------------------------------------------------------------
`default_nettype none

module lmtc_cfg
    import lmtc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic [2:0] cfg_index,
    input  wire logic [7:0] cfg_wdata,
    output cfg_t            cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                REG_DISPLAY_ENABLE:     cfg_reg.display_enable     <= cfg_wdata[0];
                REG_COMPARE_LINE:       cfg_reg.compare_line       <= cfg_wdata;
                REG_HBLANK_IRQ_ENABLE:  cfg_reg.hblank_irq_enable  <= cfg_wdata[0];
                REG_OAM_IRQ_ENABLE:     cfg_reg.oam_irq_enable     <= cfg_wdata[0];
                REG_COMPARE_IRQ_ENABLE: cfg_reg.compare_irq_enable <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- src/lmtc_core.sv -----
// ----------------------------------------------------------------------------
// LCD mode timing controller step core
// Holds the dot counter, line, mode and flags, and computes one step.
// ----------------------------------------------------------------------------
`default_nettype none

module lmtc_core
    import lmtc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step_en,
    input  wire logic [7:0] dots,
    input  wire cfg_t       cfg,
    output result_t         result
);

    logic [DOT_W-1:0]  dot_count_reg, dot_count_next;
    logic [LINE_W-1:0] line_reg, line_next;
    lcd_mode_t         mode_reg, mode_next;
    logic              match_reg, match_next;
    logic              drawn_reg, drawn_next;

    logic [DOT_W-1:0]  dsum;
    logic [DOT_W-1:0]  dwrap;
    logic [LINE_W-1:0] line_inc;
    logic              line_change;

    always_comb begin
        dsum     = dot_count_reg + {2'b00, dots};
        dwrap    = dsum - LINE_DOTS;
        line_inc = line_reg + 8'd1;

        dot_count_next = dot_count_reg;
        line_next      = line_reg;
        mode_next      = mode_reg;
        match_next     = match_reg;
        drawn_next     = drawn_reg;
        line_change    = 1'b0;
        result         = '0;

        if (!cfg.display_enable) begin
            dot_count_next = '0;
            line_next      = '0;
        end else begin
            dot_count_next = dsum;
            if (mode_reg == LCD_VBLANK) begin
                if (dsum >= LINE_DOTS) begin
                    dot_count_next = dwrap;
                    line_next      = line_inc;
                    drawn_next     = 1'b0;
                    line_change    = 1'b1;
                    if (line_inc >= FRAME_LINES) begin
                        mode_next       = LCD_OAM;
                        line_next       = '0;
                        result.mode_irq = cfg.oam_irq_enable;
                    end
                end
            end else if (dsum <= OAM_END) begin
                mode_next       = LCD_OAM;
                result.mode_irq = (mode_reg != LCD_OAM) && cfg.oam_irq_enable;
            end else if (dsum <= XFER_END) begin
                mode_next = LCD_XFER;
                if (!drawn_reg) begin
                    result.render_request = 1'b1;
                    drawn_next            = 1'b1;
                end
            end else if (dsum <= HBLANK_END) begin
                mode_next       = LCD_HBLANK;
                result.mode_irq = (mode_reg != LCD_HBLANK) && cfg.hblank_irq_enable;
            end else begin
                dot_count_next = dwrap;
                line_next      = line_inc;
                drawn_next     = 1'b0;
                line_change    = 1'b1;
                if (line_inc >= ACTIVE_LINES) begin
                    mode_next         = LCD_VBLANK;
                    result.vblank_irq = 1'b1;
                    result.frame_done = 1'b1;
                end else begin
                    mode_next       = LCD_OAM;
                    result.mode_irq = (mode_reg != LCD_OAM) && cfg.oam_irq_enable;
                end
            end
            if (line_change) begin
                match_next         = (line_next == cfg.compare_line);
                result.compare_irq = match_next && cfg.compare_irq_enable;
            end
        end

        result.line_number = line_next;
        result.lcd_mode    = mode_next;
        result.coincidence = match_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_count_reg <= '0;
            line_reg      <= '0;
            mode_reg      <= LCD_HBLANK;
            match_reg     <= 1'b0;
            drawn_reg     <= 1'b0;
        end else if (step_en) begin
            dot_count_reg <= dot_count_next;
            line_reg      <= line_next;
            mode_reg      <= mode_next;
            match_reg     <= match_next;
            drawn_reg     <= drawn_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/lcd_mode_timing_controller_unit.sv -----
// ----------------------------------------------------------------------------
// LCD mode timing controller
// Scanline dot sequencer with mode, coincidence and interrupt outputs.
// ----------------------------------------------------------------------------
// Each item carries the dots elapsed since the previous item and yields one
// result item with the line, mode, coincidence flag and the interrupt, render
// and frame pulses of that step. An item passes an input register and one
// step of the timing state into a result register. One item is accepted
// every cycle while results are taken; the dot counter and line state are
// updated from their own registers, which sets that rate. Configuration
// registers are written through cfg_wr_en, cfg_index and cfg_wdata; the user
// must write them only while no item is in flight, which is not enforced.
`default_nettype none

module lcd_mode_timing_controller_unit
    import lmtc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic [2:0] cfg_index,
    input  wire logic [7:0] cfg_wdata,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_dots_elapsed,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_line_number,
    output logic [1:0]      m_lcd_mode,
    output logic            m_coincidence,
    output logic            m_vblank_irq,
    output logic            m_mode_irq,
    output logic            m_compare_irq,
    output logic            m_render_request,
    output logic            m_frame_done
);

    cfg_t       cfg;
    result_t    step_result;
    result_t    result_reg;
    logic       in_valid_reg;
    logic [7:0] dots_reg;
    logic       m_valid_reg;
    logic       advance;

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    lmtc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    lmtc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .dots    (dots_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            dots_reg <= s_dots_elapsed;
        end
        if (advance) begin
            result_reg <= step_result;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_line_number    = result_reg.line_number;
    assign m_lcd_mode       = result_reg.lcd_mode;
    assign m_coincidence    = result_reg.coincidence;
    assign m_vblank_irq     = result_reg.vblank_irq;
    assign m_mode_irq       = result_reg.mode_irq;
    assign m_compare_irq    = result_reg.compare_irq;
    assign m_render_request = result_reg.render_request;
    assign m_frame_done     = result_reg.frame_done;

`ifndef SYNTHESIS
    a_vblank_entry : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_vblank_irq) |->
            (m_lcd_mode == LCD_VBLANK && m_line_number == ACTIVE_LINES))
        else $error("vblank pulse outside vblank entry");

    a_frame_pulse : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_frame_done == m_vblank_irq))
        else $error("frame done and vblank pulses disagree");

    a_render_mode : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_render_request) |-> (m_lcd_mode == LCD_XFER))
        else $error("render request outside pixel transfer");

    a_line_range : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_line_number < FRAME_LINES))
        else $error("line number beyond last line");
`endif

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// LCD mode timing controller testbench
// Feeds dot counts into the scanline sequencer through phases of register
// settings and handshake idling, predicts every result item from its own model
// of the line, mode and interrupt state, and checks each result item against
// the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lmtc_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 5000;
    localparam int MAX_REPORTS = 10;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    class lcd_timing_scoreboard;
        cfg_t       cfg;
        logic [9:0] dot_count;
        logic [7:0] scan_line;
        lcd_mode_t  mode;
        logic       match_flag;
        logic       line_drawn;
        result_t    expected_results[$];
        int         errors;

        function new();
            cfg        = '0;
            dot_count  = '0;
            scan_line  = '0;
            mode       = LCD_HBLANK;
            match_flag = 1'b0;
            line_drawn = 1'b0;
            errors     = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [7:0] data);
            case (idx)
                REG_DISPLAY_ENABLE:     cfg.display_enable     = data[0];
                REG_COMPARE_LINE:       cfg.compare_line       = data;
                REG_HBLANK_IRQ_ENABLE:  cfg.hblank_irq_enable  = data[0];
                REG_OAM_IRQ_ENABLE:     cfg.oam_irq_enable     = data[0];
                REG_COMPARE_IRQ_ENABLE: cfg.compare_irq_enable = data[0];
                default: ;
            endcase
        endfunction

        function logic line_compare();
            match_flag = (scan_line == cfg.compare_line);
            return match_flag && cfg.compare_irq_enable;
        endfunction

        function void note_item(logic [7:0] dots);
            result_t    r;
            logic [9:0] d;
            lcd_mode_t  prev;
            r = '0;
            if (!cfg.display_enable) begin
                dot_count = '0;
                scan_line = '0;
            end else begin
                d    = dot_count + {2'b00, dots};
                prev = mode;
                if (prev == LCD_VBLANK) begin
                    if (d >= LINE_DOTS) begin
                        d          = d - LINE_DOTS;
                        scan_line  = scan_line + 8'd1;
                        line_drawn = 1'b0;
                        if (scan_line >= FRAME_LINES) begin
                            mode       = LCD_OAM;
                            scan_line  = '0;
                            r.mode_irq = cfg.oam_irq_enable;
                        end
                        r.compare_irq = line_compare();
                    end
                end else if (d <= OAM_END) begin
                    mode       = LCD_OAM;
                    r.mode_irq = (prev != LCD_OAM) && cfg.oam_irq_enable;
                end else if (d <= XFER_END) begin
                    mode             = LCD_XFER;
                    r.render_request = !line_drawn;
                    line_drawn       = 1'b1;
                end else if (d <= HBLANK_END) begin
                    mode       = LCD_HBLANK;
                    r.mode_irq = (prev != LCD_HBLANK) && cfg.hblank_irq_enable;
                end else begin
                    d          = d - LINE_DOTS;
                    scan_line  = scan_line + 8'd1;
                    line_drawn = 1'b0;
                    if (scan_line >= ACTIVE_LINES) begin
                        mode         = LCD_VBLANK;
                        r.vblank_irq = 1'b1;
                        r.frame_done = 1'b1;
                    end else begin
                        mode       = LCD_OAM;
                        r.mode_irq = (prev != LCD_OAM) && cfg.oam_irq_enable;
                    end
                    r.compare_irq = line_compare();
                end
                dot_count = d;
            end
            r.line_number = scan_line;
            r.lcd_mode    = mode;
            r.coincidence = match_flag;
            expected_results.push_back(r);
        endfunction

        function void check_result(result_t got);
            result_t want;
            logic    bad;
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result item: line=%0d mode=%0d",
                             got.line_number, got.lcd_mode);
                return;
            end
            want = expected_results.pop_front();
            bad = (got.line_number !== want.line_number) ||
                  (got.lcd_mode !== want.lcd_mode) ||
                  (got.coincidence !== want.coincidence) ||
                  (got.vblank_irq !== want.vblank_irq) ||
                  (got.mode_irq !== want.mode_irq) ||
                  (got.compare_irq !== want.compare_irq) ||
                  (got.render_request !== want.render_request) ||
                  (got.frame_done !== want.frame_done);
            if (bad) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display({"mismatch: expected line=%0d mode=%0d coin/vbl/mirq/cirq/rend/",
                              "frame=%b%b%b%b%b%b, got line=%0d mode=%0d flags=%b%b%b%b%b%b"},
                             want.line_number, want.lcd_mode, want.coincidence,
                             want.vblank_irq, want.mode_irq, want.compare_irq,
                             want.render_request, want.frame_done,
                             got.line_number, got.lcd_mode, got.coincidence,
                             got.vblank_irq, got.mode_irq, got.compare_irq,
                             got.render_request, got.frame_done);
            end
        endfunction
    endclass

    logic       aclk           = 1'b0;
    logic       aresetn        = 1'b0;
    logic       cfg_wr_en      = 1'b0;
    logic [2:0] cfg_index      = 3'd0;
    logic [7:0] cfg_wdata      = 8'd0;
    logic       s_valid        = 1'b0;
    logic       s_ready;
    logic [7:0] s_dots_elapsed = 8'd0;
    logic       m_valid;
    logic       m_ready        = 1'b0;
    logic [7:0] m_line_number;
    logic [1:0] m_lcd_mode;
    logic       m_coincidence;
    logic       m_vblank_irq;
    logic       m_mode_irq;
    logic       m_compare_irq;
    logic       m_render_request;
    logic       m_frame_done;

    result_t    seen;
    idle_mode_t idle_mode     = IDLE_NONE;
    int         hold_requests = 0;
    int         holds_served  = 0;
    int         hold_left     = 0;
    int         stall_cycles  = 0;

    lcd_timing_scoreboard timing_board;

    lcd_mode_timing_controller_unit u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_dots_elapsed   (s_dots_elapsed),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_line_number    (m_line_number),
        .m_lcd_mode       (m_lcd_mode),
        .m_coincidence    (m_coincidence),
        .m_vblank_irq     (m_vblank_irq),
        .m_mode_irq       (m_mode_irq),
        .m_compare_irq    (m_compare_irq),
        .m_render_request (m_render_request),
        .m_frame_done     (m_frame_done)
    );

    assign seen = {m_line_number, m_lcd_mode, m_coincidence, m_vblank_irq,
                   m_mode_irq, m_compare_irq, m_render_request, m_frame_done};

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic int sender_idle_pct(idle_mode_t mode);
        return (mode == IDLE_SENDER) ? 85 : (mode == IDLE_BOTH) ? 29 : 0;
    endfunction

    function automatic int receiver_stall_pct(idle_mode_t mode);
        return (mode == IDLE_RECEIVER) ? 85 : (mode == IDLE_BOTH) ? 29 : 0;
    endfunction

    always @(posedge aclk) begin
        if (hold_requests != holds_served) begin
            holds_served <= hold_requests;
            hold_left    <= HOLD_CYCLES;
            m_ready      <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= receiver_stall_pct(idle_mode));
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            timing_board.check_result(seen);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic logic [7:0] next_dots();
        int r;
        r = $urandom_range(99);
        if (r < 45) return 8'($urandom_range(24));
        if (r < 75) return 8'($urandom_range(180, 25));
        return 8'($urandom_range(255, 181));
    endfunction

    task automatic send_item(logic [7:0] dots);
        while ($urandom_range(99) < sender_idle_pct(idle_mode)) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_dots_elapsed <= dots;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        timing_board.note_item(dots);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (timing_board.expected_results.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [7:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        timing_board.write_reg(idx, data);
    endtask

    task automatic configure(idle_mode_t mode, logic en, logic [7:0] cmp,
                             logic hb, logic oam, logic ci);
        idle_mode <= mode;
        write_reg(REG_DISPLAY_ENABLE, {7'd0, en});
        write_reg(REG_COMPARE_LINE, cmp);
        write_reg(REG_HBLANK_IRQ_ENABLE, {7'd0, hb});
        write_reg(REG_OAM_IRQ_ENABLE, {7'd0, oam});
        write_reg(REG_COMPARE_IRQ_ENABLE, {7'd0, ci});
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_phase(int n, idle_mode_t mode, logic en, logic [7:0] cmp,
                                logic hb, logic oam, logic ci, bit long_hold);
        configure(mode, en, cmp, hb, oam, ci);
        if (long_hold) hold_requests <= hold_requests + 1;
        repeat (n) send_item(next_dots());
        drain();
    endtask

    initial begin
        logic [7:0] directed[$];
        directed = '{8'd0, 8'd79, 8'd1, 8'd1, 8'd170, 8'd1, 8'd1, 8'd203, 8'd1,
                     8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd128, 8'd127,
                     8'd200, 8'd56};
        timing_board = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // With the display still off after reset, the sequencer must hold line zero.
        send_item(8'd0);
        send_item(8'd255);
        drain();

        configure(IDLE_NONE, 1'b1, 8'd2, 1'b1, 1'b1, 1'b1);
        foreach (directed[i]) send_item(directed[i]);
        drain();

        random_phase(300, IDLE_NONE, 1'b1, 8'd153, 1'b1, 1'b1, 1'b1, 1'b1);
        random_phase(300, IDLE_SENDER, 1'b1, 8'd144, 1'b0, 1'b1, 1'b1, 1'b0);
        random_phase(300, IDLE_RECEIVER, 1'b1, 8'($urandom_range(153)),
                     1'b1, 1'b0, 1'b1, 1'b0);
        random_phase(30, IDLE_BOTH, 1'b0, 8'd255, 1'b0, 1'b0, 1'b0, 1'b0);
        random_phase(300, IDLE_BOTH, 1'b1, 8'd0, 1'b1, 1'b1, 1'b1, 1'b0);
        for (int p = 0; p < 4; p++) begin
            random_phase(160, idle_mode_t'(p), ($urandom_range(9) != 0),
                         8'($urandom_range(255)), 1'($urandom_range(1)),
                         1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0);
        end

        repeat (4) @(posedge aclk);
        if (timing_board.errors == 0 && timing_board.expected_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
src/lmtc_pkg.sv
src/lmtc_cfg.sv
src/lmtc_core.sv
src/lcd_mode_timing_controller_unit.sv
tb/tb.sv
